FILE: design/ifc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ifc_pkg;

	typedef enum logic [1:0] {
		FN_READ  = 2'd0,
		FN_WRITE = 2'd1,
		FN_RAISE = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADOFF = 2'd1,
		ST_MASKED = 2'd2
	} status_t;

	// global register offsets
	localparam logic [11:0] OFF_REVISION  = 12'h000;
	localparam logic [11:0] OFF_SYSCONFIG = 12'h010;
	localparam logic [11:0] OFF_SYSSTATUS = 12'h014;
	localparam logic [11:0] OFF_SIR_IRQ   = 12'h040;
	localparam logic [11:0] OFF_SIR_FIQ   = 12'h044;
	localparam logic [11:0] OFF_CONTROL   = 12'h048;
	localparam logic [11:0] OFF_PROT      = 12'h04c;
	localparam logic [11:0] OFF_IDLE      = 12'h050;
	localparam logic [11:0] OFF_IRQ_PRIO  = 12'h060;
	localparam logic [11:0] OFF_FIQ_PRIO  = 12'h064;
	localparam logic [11:0] OFF_THRESH    = 12'h068;
	localparam logic [11:0] OFF_BANK_BASE = 12'h080;
	localparam logic [11:0] OFF_LVL_BASE  = 12'h100;

	// per-bank register offsets
	localparam logic [4:0] BK_ITR       = 5'h00;
	localparam logic [4:0] BK_MIR       = 5'h04;
	localparam logic [4:0] BK_MIR_CLEAR = 5'h08;
	localparam logic [4:0] BK_MIR_SET   = 5'h0c;
	localparam logic [4:0] BK_ISR_SET   = 5'h10;
	localparam logic [4:0] BK_ISR_CLEAR = 5'h14;
	localparam logic [4:0] BK_PEND_IRQ  = 5'h18;
	localparam logic [4:0] BK_PEND_FIQ  = 5'h1c;

	localparam logic [31:0] REVISION_VAL = 32'h0000_0050;
	localparam logic [31:0] ACTIVE_RST   = 32'hffff_ff80;
	localparam logic [31:0] PRIO_RST     = 32'hffff_ffc0;
	localparam logic [31:0] THRESH_RST   = 32'h0000_00ff;

	localparam logic [31:0] ACK_IRQ = 32'd1;
	localparam logic [31:0] ACK_FIQ = 32'd2;

endpackage
`default_nettype wire

FILE: design/irq_fiq_interrupt_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// An item passes through the input register and then the result register.
// Throughput: one item per cycle unless results stall; the level-word RAM read at
// input accept and its write at result time are bypassed so back-to-back items see
// each other. Reset: arst_n resets all controller state; a SYSCONFIG soft reset does
// the same but sets SYSSTATUS to 1 (level words drop through their valid bits).
module irq_fiq_interrupt_controller #(
	parameter int NUM_LINES = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [11:0] offset,
	input  wire logic [31:0] wdata,
	input  wire logic [6:0]  line,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      rdata,
	output logic [1:0]       status,
	output logic             irq_asserted,
	output logic             fiq_asserted
);
	import ifc_pkg::*;

	localparam int NB = (NUM_LINES + 31) / 32;
	localparam int FLAT = NB * 32;
	localparam int FW = $clog2(FLAT);
	localparam int BW = (NB > 1) ? $clog2(NB) : 1;
	localparam int IW = $clog2(NUM_LINES);
	localparam logic [11:0] LVL_LAST = 12'(256 + 4 * (NUM_LINES - 1));
	localparam logic [11:0] BANK_END = 12'(128 + 32 * NB);
	localparam logic [7:0]  NL8 = 8'(NUM_LINES);

	// ---------------- input side
	logic          in_acc, adv;
	logic          v_s1;
	func_t         func_s1;
	logic [11:0]   off_s1;
	logic [31:0]   wdata_s1;
	logic [6:0]    rline_s1;
	logic          raise_s1;
	logic [IW-1:0] lidx_s1;

	logic          bank_in, lvl_in, isr_set_in;
	logic [4:0]    ctz;
	logic [6:0]    rline_in;
	logic [9:0]    lword_in;
	logic [IW-1:0] lidx_in;

	assign in_acc = in_valid && in_ready;
	assign in_ready = !v_s1 || adv;

	always_comb begin
		ctz = 5'd0;
		for (int b = 31; b >= 0; b--) begin
			if (wdata[b])
				ctz = 5'(b);
		end
	end

	assign bank_in = offset >= OFF_BANK_BASE && offset < BANK_END;
	assign lvl_in = offset >= OFF_LVL_BASE && offset <= LVL_LAST;
	assign isr_set_in = func == FN_WRITE && bank_in && offset[4:0] == BK_ISR_SET;
	assign rline_in = (func == FN_RAISE) ? line : {offset[6:5], ctz};
	assign lword_in = 10'((offset - OFF_LVL_BASE) >> 2);
	// a raise looks up its own line, whatever the offset field holds
	assign lidx_in = (lvl_in && func != FN_RAISE) ? lword_in[IW-1:0] : rline_in[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1  <= func_t'(func);
			off_s1   <= offset;
			wdata_s1 <= wdata;
			rline_s1 <= rline_in;
			raise_s1 <= func == FN_RAISE || (isr_set_in && wdata != 32'd0);
			lidx_s1  <= lidx_in;
		end
	end

	// ---------------- state
	logic [FLAT-1:0] raw_q, mask_q, pirq_q, pfiq_q;
	logic [31:0] act_irq_q, act_fiq_q, pri_irq_q, pri_fiq_q, thr_q;
	logic [31:0] sysst_q, prot_q, idle_q;
	logic        irq_q, fiq_q;

	logic [FLAT-1:0] raw_n, mask_n, pirq_n, pfiq_n;
	logic [31:0] act_irq_n, act_fiq_n, pri_irq_n, pri_fiq_n, thr_n;
	logic [31:0] sysst_n, prot_n, idle_n;
	logic        irq_n, fiq_n;

	logic [31:0] lvl, rd;
	status_t     st;
	logic        mem_we, clr;

	ifc_lvl_store #(
		.NUM_LINES(NUM_LINES),
		.IW(IW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_acc),
		.rd_idx (lidx_in),
		.cur_idx(lidx_s1),
		.we     (mem_we && adv),
		.wdata  (wdata_s1),
		.clr    (clr && adv),
		.lvl    (lvl)
	);

	logic          bank_s1, lvl_s1_hit;
	logic [BW-1:0] bank;
	logic [5:0]    prio;
	logic [7:0]    thr8;
	logic [FW-1:0] bi, ai;

	always_comb begin
		raw_n = raw_q;  mask_n = mask_q;  pirq_n = pirq_q;  pfiq_n = pfiq_q;
		act_irq_n = act_irq_q;  act_fiq_n = act_fiq_q;
		pri_irq_n = pri_irq_q;  pri_fiq_n = pri_fiq_q;
		thr_n = thr_q;  sysst_n = sysst_q;  prot_n = prot_q;  idle_n = idle_q;
		irq_n = irq_q;  fiq_n = fiq_q;
		rd = 32'd0;
		st = ST_OK;
		mem_we = 1'b0;
		clr = 1'b0;
		bank_s1 = off_s1 >= OFF_BANK_BASE && off_s1 < BANK_END;
		lvl_s1_hit = off_s1 >= OFF_LVL_BASE && off_s1 <= LVL_LAST;
		bank = off_s1[5 +: BW];
		prio = lvl[7:2];
		thr8 = thr_q[7:0];
		bi = rline_s1[FW-1:0];
		ai = '0;
		case (func_s1)
			FN_READ: begin
				if (bank_s1) begin
					case (off_s1[4:0])
						BK_ITR:       rd = raw_q[{bank, 5'd0} +: 32];
						BK_MIR:       rd = mask_q[{bank, 5'd0} +: 32];
						BK_MIR_CLEAR, BK_MIR_SET, BK_ISR_SET, BK_ISR_CLEAR: rd = 32'd0;
						BK_PEND_IRQ:  rd = pirq_q[{bank, 5'd0} +: 32];
						BK_PEND_FIQ:  rd = pfiq_q[{bank, 5'd0} +: 32];
						default:      st = ST_BADOFF;
					endcase
				end else if (lvl_s1_hit) begin
					rd = lvl;
				end else begin
					case (off_s1)
						OFF_REVISION:  rd = REVISION_VAL;
						OFF_SYSCONFIG: rd = 32'd0;
						OFF_SYSSTATUS: rd = sysst_q;
						OFF_SIR_IRQ:   rd = act_irq_q;
						OFF_SIR_FIQ:   rd = act_fiq_q;
						OFF_PROT:      rd = prot_q;
						OFF_IDLE:      rd = idle_q;
						OFF_IRQ_PRIO:  rd = pri_irq_q;
						OFF_FIQ_PRIO:  rd = pri_fiq_q;
						OFF_THRESH:    rd = thr_q;
						default:       st = ST_BADOFF;
					endcase
				end
			end
			FN_WRITE: begin
				if (bank_s1) begin
					case (off_s1[4:0])
						BK_MIR:       mask_n[{bank, 5'd0} +: 32] = wdata_s1;
						BK_MIR_CLEAR: mask_n[{bank, 5'd0} +: 32] =
							mask_q[{bank, 5'd0} +: 32] & ~wdata_s1;
						BK_MIR_SET:   mask_n[{bank, 5'd0} +: 32] =
							mask_q[{bank, 5'd0} +: 32] | wdata_s1;
						BK_ISR_SET:   raw_n[{bank, 5'd0} +: 32] =
							raw_q[{bank, 5'd0} +: 32] | wdata_s1;
						BK_ISR_CLEAR: st = ST_OK;
						default:      st = ST_BADOFF;
					endcase
				end else if (lvl_s1_hit) begin
					mem_we = 1'b1;
				end else begin
					case (off_s1)
						OFF_SYSCONFIG: begin
							if (wdata_s1[1]) begin
								clr = 1'b1;
								raw_n = '0;  mask_n = '1;  pirq_n = '0;  pfiq_n = '0;
								act_irq_n = ACTIVE_RST;  act_fiq_n = ACTIVE_RST;
								pri_irq_n = PRIO_RST;  pri_fiq_n = PRIO_RST;
								thr_n = THRESH_RST;  sysst_n = 32'd1;
								prot_n = 32'd0;  idle_n = 32'd0;
								irq_n = 1'b0;  fiq_n = 1'b0;
							end
						end
						OFF_SIR_IRQ: act_irq_n = wdata_s1;
						OFF_CONTROL: begin
							if (wdata_s1 == ACK_IRQ) begin
								ai = act_irq_q[FW-1:0];
								if ({1'b0, act_irq_q[6:0]} < NL8) begin
									raw_n[ai] = 1'b0;
									pirq_n[ai] = 1'b0;
								end
								irq_n = 1'b0;
							end else if (wdata_s1 == ACK_FIQ) begin
								ai = act_fiq_q[FW-1:0];
								if ({1'b0, act_fiq_q[6:0]} < NL8) begin
									raw_n[ai] = 1'b0;
									pfiq_n[ai] = 1'b0;
								end
								fiq_n = 1'b0;
							end
						end
						OFF_PROT:   prot_n = wdata_s1;
						OFF_IDLE:   idle_n = wdata_s1;
						OFF_THRESH: thr_n = wdata_s1;
						default:    st = ST_BADOFF;
					endcase
				end
			end
			FN_RAISE: st = ST_OK;
			default:  st = ST_BADOFF;
		endcase

		if (raise_s1 && {1'b0, rline_s1} < NL8) begin
			raw_n[bi] = 1'b1;
			if (mask_q[bi]) begin
				if (func_s1 == FN_RAISE)
					st = ST_MASKED;
			end else begin
				if (lvl[0])
					pfiq_n[bi] = 1'b1;
				else
					pirq_n[bi] = 1'b1;
				if ({2'b00, prio} > thr8 || thr8 == 8'hff || prio == 6'd0) begin
					if (lvl[0]) begin
						act_fiq_n = {pri_fiq_q[31:7], rline_s1};
						pri_fiq_n = {pri_fiq_q[31:7], 1'b0, prio};
						fiq_n = 1'b1;
					end else begin
						act_irq_n = {pri_irq_q[31:7], rline_s1};
						pri_irq_n = {pri_irq_q[31:7], 1'b0, prio};
						irq_n = 1'b1;
					end
				end
			end
		end
	end

	assign adv = v_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= '0;  mask_q <= '1;  pirq_q <= '0;  pfiq_q <= '0;
			act_irq_q <= ACTIVE_RST;  act_fiq_q <= ACTIVE_RST;
			pri_irq_q <= PRIO_RST;  pri_fiq_q <= PRIO_RST;
			thr_q <= THRESH_RST;  sysst_q <= '0;  prot_q <= '0;  idle_q <= '0;
			irq_q <= 1'b0;  fiq_q <= 1'b0;
		end else if (adv) begin
			raw_q <= raw_n;  mask_q <= mask_n;  pirq_q <= pirq_n;  pfiq_q <= pfiq_n;
			act_irq_q <= act_irq_n;  act_fiq_q <= act_fiq_n;
			pri_irq_q <= pri_irq_n;  pri_fiq_q <= pri_fiq_n;
			thr_q <= thr_n;  sysst_q <= sysst_n;  prot_q <= prot_n;  idle_q <= idle_n;
			irq_q <= irq_n;  fiq_q <= fiq_n;
		end
	end

	// ---------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata        <= rd;
			status       <= st;
			irq_asserted <= irq_n;
			fiq_asserted <= fiq_n;
		end
	end

`ifndef SYNTHESIS
	a_soft_reset_drops: assert property (@(posedge clk) disable iff (!arst_n)
		adv && clr |=> !irq_q && !fiq_q && sysst_q == 32'd1)
		else $error("soft reset left an output asserted");
	a_out_tracks_level: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> irq_asserted == irq_q && fiq_asserted == fiq_q)
		else $error("result levels differ from controller state");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while both stages are held");
`endif

endmodule
`default_nettype wire

FILE: design/ifc_lvl_store.sv
`timescale 1ns / 1ps
`default_nettype none
module ifc_lvl_store #(
	parameter int NUM_LINES = 128,
	parameter int IW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [IW-1:0] rd_idx,
	input  wire logic [IW-1:0] cur_idx,
	input  wire logic          we,
	input  wire logic [31:0]   wdata,
	input  wire logic          clr,
	output logic      [31:0]   lvl
);

	logic [31:0]          mem [NUM_LINES];
	logic [31:0]          data_s1;
	logic [NUM_LINES-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[cur_idx] <= wdata;
	end

	// forward a write that lands on the same edge as the read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (we && cur_idx == rd_idx)
				data_s1 <= wdata;
			else
				data_s1 <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[cur_idx] <= 1'b1;
		end
	end

	assign lvl = vld_q[cur_idx] ? data_s1 : 32'd0;

endmodule
`default_nettype wire

FILE: dv/irq_fiq_interrupt_controller_tb.sv
`timescale 1ns / 1ps
module irq_fiq_interrupt_controller_tb;
	import ifc_pkg::*;

	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int ITEM_COUNT = 1050;

	typedef struct packed {
		logic [31:0] rdata;
		logic [1:0]  status;
		logic        irq;
		logic        fiq;
	} intc_result_t;

	class intc_scoreboard;
		logic [31:0] raw_bits[4], mask_bits[4], pend_irq[4], pend_fiq[4];
		logic [31:0] level_word[128];
		logic [31:0] act_irq, act_fiq, prio_irq, prio_fiq, thresh, sysstatus, prot, idle;
		logic irq_level, fiq_level;
		intc_result_t expected_q[$];
		int errors;

		function new();
			errors = 0;
			restore_defaults();
		endfunction

		function void restore_defaults();
			for (int i = 0; i < 4; i++) begin
				raw_bits[i] = '0;
				mask_bits[i] = '1;
				pend_irq[i] = '0;
				pend_fiq[i] = '0;
			end
			for (int i = 0; i < 128; i++)
				level_word[i] = '0;
			act_irq = ACTIVE_RST;
			act_fiq = ACTIVE_RST;
			prio_irq = PRIO_RST;
			prio_fiq = PRIO_RST;
			thresh = THRESH_RST;
			sysstatus = '0;
			prot = '0;
			idle = '0;
			irq_level = 1'b0;
			fiq_level = 1'b0;
		endfunction

		function status_t assert_line(logic [6:0] ln);
			logic [1:0] bank;
			logic [31:0] bitm, lv, pr, th;
			bank = ln[6:5];
			bitm = 32'd1 << ln[4:0];
			raw_bits[bank] |= bitm;
			if ((mask_bits[bank] & bitm) != 0)
				return ST_MASKED;
			lv = level_word[ln];
			th = thresh & 32'hff;
			pr = (lv >> 2) & 32'h3f;
			if (lv[0])
				pend_fiq[bank] |= bitm;
			else
				pend_irq[bank] |= bitm;
			if (pr > th || th == 32'hff || pr == 0) begin
				if (lv[0]) begin
					act_fiq = (prio_fiq & ~32'h7f) | {25'd0, ln};
					prio_fiq = (prio_fiq & ~32'h7f) | pr;
					fiq_level = 1'b1;
				end else begin
					act_irq = (prio_irq & ~32'h7f) | {25'd0, ln};
					prio_irq = (prio_irq & ~32'h7f) | pr;
					irq_level = 1'b1;
				end
			end
			return ST_OK;
		endfunction

		function void ack_active(logic [31:0] val);
			logic [6:0] ln;
			if (val == ACK_IRQ) begin
				ln = act_irq[6:0];
				raw_bits[ln[6:5]] &= ~(32'd1 << ln[4:0]);
				pend_irq[ln[6:5]] &= ~(32'd1 << ln[4:0]);
				irq_level = 1'b0;
			end else if (val == ACK_FIQ) begin
				ln = act_fiq[6:0];
				raw_bits[ln[6:5]] &= ~(32'd1 << ln[4:0]);
				pend_fiq[ln[6:5]] &= ~(32'd1 << ln[4:0]);
				fiq_level = 1'b0;
			end
		endfunction

		function status_t read_reg(logic [11:0] off, output logic [31:0] rd);
			logic [11:0] rel;
			logic [1:0] bank;
			rd = '0;
			rel = off - OFF_BANK_BASE;
			bank = rel[6:5];
			if (off >= OFF_BANK_BASE && off < OFF_LVL_BASE) begin
				case (off[4:0])
					BK_ITR: rd = raw_bits[bank];
					BK_MIR: rd = mask_bits[bank];
					BK_MIR_CLEAR, BK_MIR_SET, BK_ISR_SET, BK_ISR_CLEAR: rd = '0;
					BK_PEND_IRQ: rd = pend_irq[bank];
					BK_PEND_FIQ: rd = pend_fiq[bank];
					default: return ST_BADOFF;
				endcase
				return ST_OK;
			end
			if (off >= OFF_LVL_BASE && off <= 12'h2fc) begin
				rel = off - OFF_LVL_BASE;
				rd = level_word[rel[8:2]];
				return ST_OK;
			end
			case (off)
				OFF_REVISION:  rd = REVISION_VAL;
				OFF_SYSCONFIG: rd = '0;
				OFF_SYSSTATUS: rd = sysstatus;
				OFF_SIR_IRQ:   rd = act_irq;
				OFF_SIR_FIQ:   rd = act_fiq;
				OFF_PROT:      rd = prot;
				OFF_IDLE:      rd = idle;
				OFF_IRQ_PRIO:  rd = prio_irq;
				OFF_FIQ_PRIO:  rd = prio_fiq;
				OFF_THRESH:    rd = thresh;
				default: return ST_BADOFF;
			endcase
			return ST_OK;
		endfunction

		function status_t write_reg(logic [11:0] off, logic [31:0] val);
			logic [11:0] rel;
			logic [1:0] bank;
			status_t ignored;
			rel = off - OFF_BANK_BASE;
			bank = rel[6:5];
			if (off >= OFF_BANK_BASE && off < OFF_LVL_BASE) begin
				case (off[4:0])
					BK_MIR:       mask_bits[bank] = val;
					BK_MIR_CLEAR: mask_bits[bank] &= ~val;
					BK_MIR_SET:   mask_bits[bank] |= val;
					BK_ISR_SET: begin
						raw_bits[bank] |= val;
						// only the lowest set bit becomes a raise
						for (int b = 0; b < 32; b++)
							if (val[b]) begin
								ignored = assert_line({bank, b[4:0]});
								break;
							end
					end
					BK_ISR_CLEAR: ;
					default: return ST_BADOFF;
				endcase
				return ST_OK;
			end
			if (off >= OFF_LVL_BASE && off <= 12'h2fc) begin
				rel = off - OFF_LVL_BASE;
				level_word[rel[8:2]] = val;
				return ST_OK;
			end
			case (off)
				OFF_SYSCONFIG:
					if (val[1]) begin
						restore_defaults();
						sysstatus[0] = 1'b1;
					end
				OFF_SIR_IRQ: act_irq = val;
				OFF_CONTROL: ack_active(val);
				OFF_PROT:    prot = val;
				OFF_IDLE:    idle = val;
				OFF_THRESH:  thresh = val;
				default: return ST_BADOFF;
			endcase
			return ST_OK;
		endfunction

		function void note_item(logic [1:0] fn, logic [11:0] off, logic [31:0] wd,
				logic [6:0] ln);
			intc_result_t r;
			logic [31:0] rd;
			rd = '0;
			case (fn)
				FN_READ:  r.status = read_reg(off, rd);
				FN_WRITE: r.status = write_reg(off, wd);
				FN_RAISE: r.status = assert_line(ln);
				default:  r.status = ST_BADOFF;
			endcase
			r.rdata = rd;
			r.irq = irq_level;
			r.fiq = fiq_level;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [31:0] rd, logic [1:0] st, logic irq, logic fiq);
			intc_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result rdata=%h status=%0d", $time, rd, st);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (rd !== e.rdata) begin
				$display("%0t: rdata expected %h actual %h", $time, e.rdata, rd);
				errors++;
			end
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (irq !== e.irq) begin
				$display("%0t: irq expected %b actual %b", $time, e.irq, irq);
				errors++;
			end
			if (fiq !== e.fiq) begin
				$display("%0t: fiq expected %b actual %b", $time, e.fiq, fiq);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] func;
	logic [11:0] offset;
	logic [31:0] wdata;
	logic [6:0] line;
	logic [31:0] rdata;
	logic [1:0] status;
	logic irq_asserted, fiq_asserted;

	intc_scoreboard sb;
	int send_idle_pct, recv_stall_pct;
	int hold_request, hold_left;

	irq_fiq_interrupt_controller dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .offset(offset), .wdata(wdata), .line(line),
		.out_valid(out_valid), .out_ready(out_ready),
		.rdata(rdata), .status(status),
		.irq_asserted(irq_asserted), .fiq_asserted(fiq_asserted)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(rdata, status, irq_asserted, fiq_asserted);

	task automatic send_item(logic [1:0] fn, logic [11:0] off, logic [31:0] wd,
			logic [6:0] ln);
		in_valid <= 1'b1;
		func <= fn;
		offset <= off;
		wdata <= wd;
		line <= ln;
		do @(posedge clk); while (!in_ready);
		sb.note_item(fn, off, wd, ln);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic logic [11:0] pick_bank_reg(logic [4:0] sub);
		return OFF_BANK_BASE + {5'd0, 2'($urandom_range(3)), 5'd0} + {7'd0, sub};
	endfunction

	task automatic send_random_item();
		int kind;
		logic [31:0] wd;
		logic [11:0] off;
		kind = $urandom_range(99);
		wd = $urandom;
		if (kind < 12) begin
			// unmask, mostly one line at a time
			wd = ($urandom_range(3) == 0) ? $urandom : (32'd1 << $urandom_range(31));
			send_item(FN_WRITE, pick_bank_reg(BK_MIR_CLEAR), wd, 7'($urandom));
		end else if (kind < 16) begin
			case ($urandom_range(2))
				0: off = pick_bank_reg(BK_MIR);
				1: off = pick_bank_reg(BK_MIR_SET);
				default: off = pick_bank_reg(BK_ISR_CLEAR);
			endcase
			send_item(FN_WRITE, off, wd, 7'($urandom));
		end else if (kind < 30) begin
			off = OFF_LVL_BASE + {3'd0, 7'($urandom), 2'($urandom_range(3) == 0 ? $urandom : 0)};
			if ($urandom_range(1)) wd = {24'd0, 6'($urandom_range(3) == 0 ? 0 : $urandom), 1'b0, 1'($urandom)};
			send_item(FN_WRITE, off, wd, 7'($urandom));
		end else if (kind < 55) begin
			send_item(FN_RAISE, 12'($urandom), wd, 7'($urandom));
		end else if (kind < 62) begin
			if ($urandom_range(4) == 0) wd = '0;
			else if ($urandom_range(1)) wd = 32'd1 << $urandom_range(31);
			send_item(FN_WRITE, pick_bank_reg(BK_ISR_SET), wd, 7'($urandom));
		end else if (kind < 72) begin
			wd = ($urandom_range(5) == 0) ? $urandom : ($urandom_range(1) ? ACK_IRQ : ACK_FIQ);
			send_item(FN_WRITE, OFF_CONTROL, wd, 7'($urandom));
		end else if (kind < 76) begin
			case ($urandom_range(2))
				0: wd = THRESH_RST;
				1: wd = $urandom_range(63);
				default: ;
			endcase
			send_item(FN_WRITE, OFF_THRESH, wd, 7'($urandom));
		end else if (kind < 78) begin
			if ($urandom_range(3) != 0) wd[1] = 1'b0;
			send_item(FN_WRITE, OFF_SYSCONFIG, wd, 7'($urandom));
		end else if (kind < 81) begin
			case ($urandom_range(2))
				0: off = OFF_SIR_IRQ;
				1: off = OFF_PROT;
				default: off = OFF_IDLE;
			endcase
			send_item(FN_WRITE, off, wd, 7'($urandom));
		end else if (kind < 95) begin
			case ($urandom_range(3))
				0: off = pick_bank_reg(5'($urandom_range(7) * 4));
				1: off = OFF_LVL_BASE + {3'd0, 7'($urandom), 2'd0};
				2: off = 12'($urandom_range(26) * 4);
				default: off = 12'($urandom);
			endcase
			send_item(FN_READ, off, wd, 7'($urandom));
		end else begin
			send_item($urandom_range(98) == 0 ? FN_UNUSED : 2'($urandom_range(1)),
				12'($urandom), wd, 7'($urandom));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		func = FN_READ;
		offset = '0;
		wdata = '0;
		line = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(FN_READ, OFF_REVISION, '0, '0);
		send_item(FN_READ, 12'hfff, '0, '0);
		send_item(FN_UNUSED, OFF_REVISION, '1, '1);
		send_item(FN_RAISE, '0, '0, 7'd5);
		send_item(FN_WRITE, pick_bank_reg(BK_MIR_CLEAR), '1, '0);
		send_item(FN_WRITE, OFF_LVL_BASE + 12'h1fc, 32'h0000_0009, '0);
		send_item(FN_WRITE, OFF_LVL_BASE + 12'd8, 32'h0000_0010, '0);
		send_item(FN_WRITE, OFF_BANK_BASE + 12'h04, 32'h0, '0);
		send_item(FN_WRITE, OFF_BANK_BASE + 12'h64, 32'h0, '0);
		send_item(FN_RAISE, '0, '0, 7'd127);
		send_item(FN_RAISE, '0, '0, 7'd0);
		send_item(FN_WRITE, OFF_THRESH, 32'd0, '0);
		send_item(FN_RAISE, '0, '0, 7'd2);
		send_item(FN_READ, OFF_LVL_BASE + 12'h1fd, '0, '0);
		send_item(FN_READ, OFF_BANK_BASE + 12'h08, '0, '0);
		send_item(FN_WRITE, OFF_BANK_BASE + 12'h10, 32'h0, '0);
		send_item(FN_WRITE, OFF_BANK_BASE + 12'h30, 32'h8000_0100, '0);
		send_item(FN_WRITE, OFF_BANK_BASE + 12'h14, '1, '0);
		send_item(FN_WRITE, OFF_SIR_FIQ, '1, '0);
		send_item(FN_WRITE, OFF_CONTROL, ACK_IRQ, '0);
		send_item(FN_WRITE, OFF_CONTROL, ACK_FIQ, '0);
		send_item(FN_WRITE, OFF_CONTROL, 32'd5, '0);
		send_item(FN_WRITE, OFF_SYSCONFIG, 32'd2, '0);
		send_item(FN_READ, OFF_SYSSTATUS, '0, '0);
		send_item(FN_READ, OFF_BANK_BASE + 12'h04, '0, '0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			// long receiver hold-off while items keep coming
			if (phase == 0) hold_request = 300;
			for (int i = 0; i < ITEM_COUNT / 4; i++)
				send_random_item();
		end
		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule

FILE: sim.f
design/ifc_pkg.sv
design/ifc_lvl_store.sv
design/irq_fiq_interrupt_controller.sv
dv/irq_fiq_interrupt_controller_tb.sv
